FILE: hdl/top_k_expert_router_top_macros.svh
`ifndef TOP_K_EXPERT_ROUTER_TOP_MACROS_SVH
`define TOP_K_EXPERT_ROUTER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define TKR_ASSERT_NOW(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
		else $error(msg);

// next-cycle implication
`define TKR_ASSERT_NEXT(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);

`endif

FILE: hdl/tkr_pkg.sv
package tkr_pkg;

	localparam int PROB_W     = 16;
	localparam int EXP_W      = 6;
	localparam int TOKEN_W    = 16;
	localparam int EC_W       = 7;
	localparam int SC_W       = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam int DEF_MAX_EXPERTS = 64;
	localparam int DEF_MAX_SELECT  = 8;
	localparam int DEF_MAX_TOKENS  = 65536;

	localparam logic [EC_W-1:0] EC_RESET = 7'd8;
	localparam logic [SC_W-1:0] SC_RESET = 4'd2;

	localparam logic [CFG_IDX_W-1:0] REG_EXPERT_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SELECT_COUNT = 2'd1;

	typedef struct packed {
		logic              valid;
		logic [PROB_W-1:0] prob;
		logic [EXP_W-1:0]  expert;
	} entry_t;

endpackage

FILE: hdl/tkr_in_if.sv
interface tkr_in_if;
	logic                       valid;
	logic                       ready;
	logic [tkr_pkg::PROB_W-1:0] probability;
	logic                       batch_start;

	modport source (output valid, output probability, output batch_start, input ready);
	modport sink (input valid, input probability, input batch_start, output ready);
endinterface

FILE: hdl/tkr_out_if.sv
interface tkr_out_if;
	logic                        valid;
	logic                        ready;
	logic [tkr_pkg::TOKEN_W-1:0] token_number;
	logic [tkr_pkg::EXP_W-1:0]   expert_number;
	logic [tkr_pkg::PROB_W-1:0]  routing_weight;
	logic                        last_of_token;

	modport source (output valid, output token_number, output expert_number,
		output routing_weight, output last_of_token, input ready);
	modport sink (input valid, input token_number, input expert_number,
		input routing_weight, input last_of_token, output ready);
endinterface

FILE: hdl/tkr_cfg_if.sv
interface tkr_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [tkr_pkg::CFG_IDX_W-1:0]  index;
	logic [tkr_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hdl/tkr_cell.sv
module tkr_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  logic                       flush,
	input  logic                       start,
	input  logic [tkr_pkg::PROB_W-1:0] new_prob,
	input  logic [tkr_pkg::EXP_W-1:0]  new_expert,
	input  tkr_pkg::entry_t            left_entry,
	input  logic                       left_take,
	output tkr_pkg::entry_t            cur_entry,
	output logic                       take,
	output tkr_pkg::entry_t            next_entry
);

	tkr_pkg::entry_t entry_q;

	// batch start empties the list before the insert
	always_comb begin
		cur_entry       = entry_q;
		cur_entry.valid = entry_q.valid & ~start;
	end

	// ties keep the older (lower numbered) expert ahead
	assign take = !cur_entry.valid || (entry_q.prob < new_prob);

	always_comb begin
		if (!take) begin
			next_entry = cur_entry;
		end else if (left_take) begin
			next_entry = left_entry;
		end else begin
			next_entry.valid  = 1'b1;
			next_entry.prob   = new_prob;
			next_entry.expert = new_expert;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (load) begin
			entry_q.valid  <= next_entry.valid & ~flush;
			entry_q.prob   <= next_entry.prob;
			entry_q.expert <= next_entry.expert;
		end
	end

endmodule

FILE: hdl/tkr_drain.sv
module tkr_drain #(
	parameter int MAX_SELECT = tkr_pkg::DEF_MAX_SELECT,
	parameter int SW         = $clog2(MAX_SELECT + 1)
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   load,
	input  tkr_pkg::entry_t [MAX_SELECT-1:0]       load_entries,
	input  logic [SW-1:0]                          load_count,
	input  logic [tkr_pkg::TOKEN_W-1:0]            load_token,
	output logic                                   can_load,
	tkr_out_if.source                              routes
);

	tkr_pkg::entry_t [MAX_SELECT-1:0] buf_q;
	logic [SW-1:0]                    count_q;
	logic [tkr_pkg::TOKEN_W-1:0]      token_q;
	logic                             pop;

	assign pop      = routes.valid && routes.ready;
	assign can_load = (count_q == '0) || ((count_q == SW'(1)) && routes.ready);

	assign routes.valid          = (count_q != '0);
	assign routes.token_number   = token_q;
	assign routes.expert_number  = buf_q[0].expert;
	assign routes.routing_weight = buf_q[0].prob;
	assign routes.last_of_token  = (count_q == SW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (load) begin
			count_q <= load_count;
		end else if (pop) begin
			count_q <= count_q - SW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q   <= load_entries;
			token_q <= load_token;
		end else if (pop) begin
			for (int i = 0; i < MAX_SELECT - 1; i++) begin
				buf_q[i] <= buf_q[i+1];
			end
		end
	end

endmodule

FILE: hdl/top_k_expert_router_top.sv
// Top-k expert router: a row of MAX_SELECT insertion cells keeps the sorted list.
// Throughput: one probability per cycle; the list cell row inserts each accepted one.
// Results start in the cycle after a token's last probability, then one per ready cycle.
// Input stalls only at a token's last position while the output buffer is still busy.
// Reset: async active low; list, counters and output buffer empty, expert_count 8,
// select_count 2.
`include "top_k_expert_router_top_macros.svh"

module top_k_expert_router_top #(
	parameter int MAX_EXPERTS = tkr_pkg::DEF_MAX_EXPERTS,
	parameter int MAX_SELECT  = tkr_pkg::DEF_MAX_SELECT,
	parameter int MAX_TOKENS  = tkr_pkg::DEF_MAX_TOKENS
) (
	input  logic       clk,
	input  logic       arst_n,
	tkr_in_if.sink     probs,
	tkr_out_if.source  routes,
	tkr_cfg_if.sink    cfg
);

	localparam int PW = $clog2(MAX_EXPERTS + 1);
	localparam int CW = (PW > tkr_pkg::EC_W) ? PW : tkr_pkg::EC_W;
	localparam int SW = $clog2(MAX_SELECT + 1);
	localparam int KW = (SW > tkr_pkg::SC_W) ? SW : tkr_pkg::SC_W;
	localparam int TW = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;

	logic [tkr_pkg::EC_W-1:0] expert_count_q;
	logic [tkr_pkg::SC_W-1:0] select_count_q;
	logic [PW-1:0]            pos_q;
	logic [SW-1:0]            filled_q;
	logic [TW-1:0]            token_q;

	logic          start, acc, end_tok, may_end, can_load;
	logic [CW-1:0] eff_experts;
	logic [KW-1:0] eff_select;
	logic [PW-1:0] pos_base, pos_inc;
	logic [SW-1:0] filled_next, k_count;
	logic [TW-1:0] token_base, token_inc;

	tkr_pkg::entry_t [MAX_SELECT-1:0] cur_e, next_e;
	logic [MAX_SELECT-1:0]            takes, next_valid;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expert_count_q <= tkr_pkg::EC_RESET;
			select_count_q <= tkr_pkg::SC_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				tkr_pkg::REG_EXPERT_COUNT: expert_count_q <= cfg.data[tkr_pkg::EC_W-1:0];
				tkr_pkg::REG_SELECT_COUNT: select_count_q <= cfg.data[tkr_pkg::SC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (expert_count_q == '0) begin
			eff_experts = CW'(1);
		end else if (CW'(expert_count_q) > CW'(MAX_EXPERTS)) begin
			eff_experts = CW'(MAX_EXPERTS);
		end else begin
			eff_experts = CW'(expert_count_q);
		end
		if (select_count_q == '0) begin
			eff_select = KW'(1);
		end else if (KW'(select_count_q) > KW'(MAX_SELECT)) begin
			eff_select = KW'(MAX_SELECT);
		end else begin
			eff_select = KW'(select_count_q);
		end
	end

	assign start      = probs.batch_start;
	assign acc        = probs.valid && probs.ready;
	assign pos_base   = start ? '0 : pos_q;
	assign pos_inc    = pos_base + PW'(1);
	assign end_tok    = (CW'(pos_inc) >= eff_experts);
	assign may_end    = (CW'(pos_q + PW'(1)) >= eff_experts) || (eff_experts == CW'(1));
	assign probs.ready = !may_end || can_load;

	assign filled_next = start ? SW'(1) :
		(filled_q == SW'(MAX_SELECT)) ? filled_q : filled_q + SW'(1);
	assign k_count = (eff_select > KW'(filled_next)) ? filled_next : SW'(eff_select);

	assign token_base = start ? '0 : token_q;
	assign token_inc  = (token_base == TW'(MAX_TOKENS - 1)) ? '0 : token_base + TW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			filled_q <= '0;
			token_q  <= '0;
		end else if (acc) begin
			pos_q    <= end_tok ? '0 : pos_inc;
			filled_q <= end_tok ? '0 : filled_next;
			token_q  <= end_tok ? token_inc : token_base;
		end
	end

	for (genvar i = 0; i < MAX_SELECT; i++) begin : g_cell
		tkr_pkg::entry_t left_entry;
		logic            left_take;

		if (i == 0) begin : g_head
			assign left_entry = '0;
			assign left_take  = 1'b0;
		end else begin : g_body
			assign left_entry = cur_e[i-1];
			assign left_take  = takes[i-1];
		end

		tkr_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.load       (acc),
			.flush      (end_tok),
			.start      (start),
			.new_prob   (probs.probability),
			.new_expert (tkr_pkg::EXP_W'(pos_base)),
			.left_entry (left_entry),
			.left_take  (left_take),
			.cur_entry  (cur_e[i]),
			.take       (takes[i]),
			.next_entry (next_e[i])
		);

		assign next_valid[i] = next_e[i].valid;
	end

	tkr_drain #(
		.MAX_SELECT (MAX_SELECT),
		.SW         (SW)
	) u_drain (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (acc && end_tok),
		.load_entries (next_e),
		.load_count   (k_count),
		.load_token   (tkr_pkg::TOKEN_W'(token_base)),
		.can_load     (can_load),
		.routes       (routes)
	);

	`TKR_ASSERT_NEXT(a_end_gives_results, acc && end_tok, routes.valid, "token end without results")
	`TKR_ASSERT_NEXT(a_list_nonempty, acc && !end_tok, filled_q != '0, "list empty mid-token")
	`TKR_ASSERT_NOW(a_valid_packed, acc, (next_valid & (next_valid + MAX_SELECT'(1))) == '0, "list has holes")

endmodule
